/* rtl/tw_pkg.sv */
`timescale 1ns / 1ps
package tw_pkg;
	localparam int Slots = 256;
	localparam int Events = 64;
	localparam int SlotW = 8;
	localparam int EvW = 6;
	localparam int LinkW = 7;
	localparam logic [LinkW-1:0] NullEv = 7'd64;
	localparam logic [8:0] Idle = 9'd257;

	localparam logic [2:0] FnSched = 3'd0;
	localparam logic [2:0] FnCancel = 3'd1;
	localparam logic [2:0] FnTick = 3'd2;
	localparam logic [2:0] FnQuery = 3'd3;
	localparam logic [2:0] FnResched = 3'd4;
	localparam logic [2:0] FnExtend = 3'd5;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StBusy = 2'd1;
	localparam logic [1:0] StIdle = 2'd2;
	localparam logic [1:0] StClamp = 2'd3;

	typedef struct packed {
		logic [2:0] func;
		logic [5:0] event_id;
		logic [9:0] delay;
	} req_t;

	typedef struct packed {
		logic [5:0] fired_id;
		logic fired;
		logic last;
		logic [1:0] status;
		logic [8:0] time_left;
	} rsp_t;

	// one entry of the event table
	typedef struct packed {
		logic busy;
		logic [SlotW-1:0] slot;
		logic [LinkW-1:0] link;
	} ent_t;
endpackage

/* rtl/tw_if.sv */
`timescale 1ns / 1ps
interface tw_req_if;
	logic valid;
	logic ready;
	tw_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tw_rsp_if;
	logic valid;
	logic ready;
	tw_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/tw_ram.sv */
`timescale 1ns / 1ps
module tw_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* rtl/timing_wheel_event_scheduler_core.sv */
`timescale 1ns / 1ps
// channel  | dir | payload
// req      | in  | func, event_id, delay
// rsp      | out | fired_id, fired, last, status, time_left
// Sequential: one request at a time. Slot heads sit in a 256x7 RAM, event entries
// (busy, slot, link) in a 64x16 RAM, both with registered reads (issue, then use).
// Cancel unlinks a busy event by walking its slot list from the head, as do reschedule and
// a lengthening extend; tick returns one response per fired id, or one unfired response.
// After reset a clearing pass writes all 256 heads and 64 entries before the first
// request is taken. A response held by rsp.ready stalls the sequencer.
module timing_wheel_event_scheduler_core (
	input logic clk,
	input logic arst_n,
	tw_req_if.sink req,
	tw_rsp_if.source rsp
);
	typedef enum logic [3:0] {
		CLR, IDLE, RDE, DEC, RDH, FIX, WRD, WCHK, UNL, RDP, INS, TRD, TUSE, TRE, TLK, OUT
	} state_t;

	state_t state_q;
	logic [tw_pkg::SlotW-1:0] clr_q;
	logic [2:0] func_q;
	logic [tw_pkg::EvW-1:0] id_q;
	logic [9:0] delay_q;
	logic [tw_pkg::SlotW-1:0] cur_q;
	logic [1:0] st_q;
	logic ins_q;
	logic ebusy_q;
	logic [tw_pkg::SlotW-1:0] eslot_q;
	logic [tw_pkg::LinkW-1:0] elink_q;
	logic [tw_pkg::EvW-1:0] ptr_q;
	tw_pkg::rsp_t out_q;
	logic out_v_q;

	// head ram
	logic h_we;
	logic [tw_pkg::SlotW-1:0] h_wa, h_ra;
	logic [tw_pkg::LinkW-1:0] h_wd, h_rd;
	tw_ram #(.Width(tw_pkg::LinkW), .Depth(tw_pkg::Slots)) u_head (
		.clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
	);

	// event entry ram
	logic e_we;
	logic [tw_pkg::EvW-1:0] e_wa, e_ra;
	tw_pkg::ent_t e_wd, e_rd;
	tw_ram #(.Width($bits(tw_pkg::ent_t)), .Depth(tw_pkg::Events)) u_ent (
		.clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd)
	);

	// derived values of the held request
	logic [8:0] dcl;
	logic clamp;
	logic [tw_pkg::SlotW-1:0] pos;
	logic [tw_pkg::SlotW-1:0] left_d;
	logic [tw_pkg::SlotW-1:0] left_o;
	logic head_hit;
	logic link_hit;
	logic h_null;
	logic out_free;
	logic out_load;
	always_comb begin
		clamp = delay_q > 10'(tw_pkg::Slots);
		dcl = clamp ? 9'(tw_pkg::Slots) : delay_q[8:0];
		pos = cur_q + dcl[tw_pkg::SlotW-1:0];
		left_d = e_rd.slot - cur_q;
		left_o = eslot_q - cur_q;
		head_hit = h_rd == {1'b0, id_q};
		link_hit = e_rd.link == {1'b0, id_q};
		h_null = h_rd[tw_pkg::LinkW-1];
		out_free = !out_v_q || rsp.ready;
		out_load = out_free && ((state_q == OUT) || (state_q == TLK) ||
			((state_q == TUSE) && h_null));
	end

	assign req.ready = (state_q == IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.data = out_q;

	// ram addresses and write-backs per state
	always_comb begin
		h_we = 1'b0;
		h_wa = cur_q;
		h_wd = tw_pkg::NullEv;
		h_ra = cur_q;
		e_we = 1'b0;
		e_wa = id_q;
		e_wd = '{busy: 1'b0, slot: eslot_q, link: tw_pkg::NullEv};
		e_ra = id_q;
		case (state_q)
			CLR: begin
				h_we = 1'b1;
				h_wa = clr_q;
				e_we = 1'b1;
				e_wa = clr_q[tw_pkg::EvW-1:0];
				e_wd = '{busy: 1'b0, slot: '0, link: tw_pkg::NullEv};
			end
			RDH: h_ra = eslot_q;
			FIX: begin
				h_ra = eslot_q;
				h_wa = eslot_q;
				h_we = head_hit;
				h_wd = elink_q;
			end
			WRD: e_ra = ptr_q;
			WCHK: begin
				e_ra = ptr_q;
				e_wa = ptr_q;
				e_we = link_hit;
				e_wd = '{busy: e_rd.busy, slot: e_rd.slot, link: elink_q};
			end
			UNL: e_we = 1'b1;
			RDP: h_ra = pos;
			INS: begin
				h_ra = pos;
				h_we = 1'b1;
				h_wa = pos;
				h_wd = {1'b0, id_q};
				e_we = 1'b1;
				e_wd = '{busy: 1'b1, slot: pos, link: h_rd};
			end
			TRE: e_ra = ptr_q;
			TLK: begin
				e_ra = ptr_q;
				e_wa = ptr_q;
				e_we = out_free;
				e_wd = '{busy: 1'b0, slot: e_rd.slot, link: tw_pkg::NullEv};
				h_we = out_free;
				h_wd = e_rd.link;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLR;
			clr_q <= '0;
			cur_q <= '0;
			func_q <= '0;
			id_q <= '0;
			delay_q <= '0;
			st_q <= tw_pkg::StOk;
			ins_q <= 1'b0;
			ebusy_q <= 1'b0;
			eslot_q <= '0;
			elink_q <= tw_pkg::NullEv;
			ptr_q <= '0;
			out_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			out_v_q <= out_load || (out_v_q && !rsp.ready);
			case (state_q)
				CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= IDLE;
				end
				IDLE: if (req.valid) begin
					func_q <= req.data.func;
					id_q <= req.data.event_id;
					delay_q <= req.data.delay;
					st_q <= tw_pkg::StOk;
					ins_q <= 1'b0;
					state_q <= (req.data.func == tw_pkg::FnTick) ? TRD : RDE;
				end
				RDE: state_q <= DEC;
				DEC: begin
					ebusy_q <= e_rd.busy;
					eslot_q <= e_rd.slot;
					elink_q <= e_rd.link;
					state_q <= OUT;
					case (func_q)
						tw_pkg::FnSched:
							if (e_rd.busy) st_q <= tw_pkg::StBusy;
							else state_q <= RDP;
						tw_pkg::FnCancel:
							if (e_rd.busy) state_q <= RDH;
							else st_q <= tw_pkg::StIdle;
						tw_pkg::FnResched: begin
							ins_q <= 1'b1;
							state_q <= e_rd.busy ? RDH : RDP;
						end
						tw_pkg::FnExtend:
							if (!e_rd.busy) state_q <= RDP;
							else if (delay_q > {2'b0, left_d}) begin
								ins_q <= 1'b1;
								state_q <= RDH;
							end
						default:
							if (!e_rd.busy) st_q <= tw_pkg::StIdle;
					endcase
				end
				RDH: state_q <= FIX;
				// head is the target: head rewritten here; else walk the list
				FIX: if (head_hit) state_q <= UNL;
				else begin
					ptr_q <= h_rd[tw_pkg::EvW-1:0];
					state_q <= WRD;
				end
				WRD: state_q <= WCHK;
				WCHK: if (link_hit || e_rd.link[tw_pkg::LinkW-1]) state_q <= UNL;
				else begin
					ptr_q <= e_rd.link[tw_pkg::EvW-1:0];
					state_q <= WRD;
				end
				UNL: begin
					ebusy_q <= 1'b0;
					state_q <= ins_q ? RDP : OUT;
				end
				RDP: state_q <= INS;
				INS: begin
					ebusy_q <= 1'b1;
					eslot_q <= pos;
					if (clamp) st_q <= tw_pkg::StClamp;
					state_q <= OUT;
				end
				TRD: state_q <= TUSE;
				TUSE: if (!h_null) begin
					ptr_q <= h_rd[tw_pkg::EvW-1:0];
					state_q <= TRE;
				end else if (out_free) begin
					out_q <= '{fired_id: '0, fired: 1'b0, last: 1'b1,
						status: tw_pkg::StOk, time_left: '0};
					cur_q <= cur_q + 1'b1;
					state_q <= IDLE;
				end
				TRE: state_q <= TLK;
				TLK: if (out_free) begin
					out_q <= '{fired_id: ptr_q, fired: 1'b1,
						last: e_rd.link[tw_pkg::LinkW-1], status: tw_pkg::StOk,
						time_left: tw_pkg::Idle};
					if (e_rd.link[tw_pkg::LinkW-1]) begin
						cur_q <= cur_q + 1'b1;
						state_q <= IDLE;
					end else begin
						ptr_q <= e_rd.link[tw_pkg::EvW-1:0];
						state_q <= TRE;
					end
				end
				OUT: if (out_free) begin
					out_q <= '{fired_id: id_q, fired: 1'b0, last: 1'b1, status: st_q,
						time_left: ebusy_q ? {1'b0, left_o} : tw_pkg::Idle};
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> state_q == IDLE) else $error("ready outside idle");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.data))
		else $error("response changed while stalled");
	a_clr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CLR) |-> !req.ready && !rsp.valid) else $error("activity during clear");
	a_plain_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.data.fired) |-> rsp.data.last)
		else $error("plain response not last");
endmodule
